// File: src/ffba_pkg.sv
package ffba_pkg;

   // fixed field widths of the ports
   localparam int CFG_W   = 5;
   localparam int SLOT_W  = 4;
   localparam int FIELD_W = 16;

   localparam logic [CFG_W-1:0] BLOCK_COUNT_RESET = 5'd16;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } ffba_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_wr;     // write the loaded size into the table
      logic out_load;    // capture the load result in the output register
      logic scan_start;  // latch wanted size, read block 0
      logic scan_next;   // advance to the next block
      logic grant;       // write back the reduced size and capture the grant
      logic out_deny;    // capture a not-allocated result
   } ffba_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;  // no block takes part in the search
      logic fits;        // current block is large enough
      logic last;        // current block is the last one searched
   } ffba_status_type;

endpackage

// File: src/ffba_ram.sv
module ffba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/ffba_ctrl.sv
module ffba_ctrl
   import ffba_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_op,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ffba_status_type status,
   output ffba_cmd_type    cmd
);

   ffba_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_LOAD) begin
                  cmd.load_wr  = 1'b1;
                  cmd.out_load = 1'b1;
               end else if (status.count_zero) begin
                  cmd.out_deny = 1'b1;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.fits) begin
               cmd.grant = 1'b1;
               state_in  = ST_IDLE;
            end else if (status.last) begin
               cmd.out_deny = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.out_load || cmd.grant || cmd.out_deny) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/ffba_datapath.sv
module ffba_datapath
   import ffba_pkg::*;
#(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [CFG_W-1:0]   csr_write_data,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic [FIELD_W-1:0] req_size_value,
   input  ffba_cmd_type       cmd,
   output ffba_status_type    status,
   output logic               rsp_granted,
   output logic [SLOT_W-1:0]  rsp_block_number,
   output logic [FIELD_W-1:0] rsp_remaining
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CMP_W = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

   logic [CFG_W-1:0]      block_count_ff;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [SIZE_WIDTH-1:0] size_ff, size_in;
   logic                  valid_ff [NUM_BLOCKS];
   logic                  rd_valid_ff;

   logic [31:0]           slot_wide, size_wide, idx_wide, rem_wide, load_wide;
   logic                  slot_ok;
   logic [IDX_W-1:0]      slot_addr;
   logic [SIZE_WIDTH-1:0] size_masked;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr, rd_addr;
   logic [SIZE_WIDTH-1:0] wr_data, rd_data, entry, entry_left;

   logic                  granted_ff, granted_in;
   logic [SLOT_W-1:0]     block_ff, block_in;
   logic [FIELD_W-1:0]    rem_ff, rem_in;

   // input fields brought to table widths
   assign slot_wide   = 32'(req_slot);
   assign slot_ok     = slot_wide < 32'(NUM_BLOCKS);
   assign slot_addr   = slot_wide[IDX_W-1:0];
   assign size_wide   = 32'(req_size_value);
   assign size_masked = size_wide[SIZE_WIDTH-1:0];

   // scan index and latched wanted size
   always_comb begin
      idx_in  = idx_ff;
      size_in = size_ff;
      rd_addr = '0;
      if (cmd.scan_start) begin
         idx_in  = '0;
         size_in = size_masked;
      end else if (cmd.scan_next) begin
         idx_in  = idx_ff + IDX_W'(1);
         rd_addr = idx_ff + IDX_W'(1);
      end
   end

   // unwritten entries read as zero
   assign entry      = rd_valid_ff ? rd_data : '0;
   assign entry_left = entry - size_ff;

   assign status.count_zero = (block_count_ff == '0);
   assign status.fits       = (entry >= size_ff);
   assign status.last       = ((CMP_W'(idx_ff) + CMP_W'(1)) == CMP_W'(block_count_ff)) ||
                              (idx_ff == IDX_W'(NUM_BLOCKS - 1));

   // table write port: loads and grant write-back
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_addr;
      wr_data = size_masked;
      if (cmd.grant) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = entry_left;
      end else if (cmd.load_wr && slot_ok) begin
         wr_en = 1'b1;
      end
   end

   ffba_ram #(
      .WIDTH (SIZE_WIDTH),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result register
   assign idx_wide  = 32'(idx_ff);
   assign rem_wide  = 32'(entry_left);
   assign load_wide = 32'(size_masked);

   always_comb begin
      granted_in = granted_ff;
      block_in   = block_ff;
      rem_in     = rem_ff;
      if (cmd.out_load) begin
         granted_in = slot_ok;
         block_in   = slot_ok ? req_slot : '0;
         rem_in     = slot_ok ? load_wide[FIELD_W-1:0] : '0;
      end else if (cmd.grant) begin
         granted_in = 1'b1;
         block_in   = idx_wide[SLOT_W-1:0];
         rem_in     = rem_wide[FIELD_W-1:0];
      end else if (cmd.out_deny) begin
         granted_in = 1'b0;
         block_in   = '0;
         rem_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      size_ff     <= size_in;
      granted_ff  <= granted_in;
      block_ff    <= block_in;
      rem_ff      <= rem_in;
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= BLOCK_COUNT_RESET;
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_write_enable) begin
            block_count_ff <= csr_write_data;
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rsp_granted      = granted_ff;
   assign rsp_block_number = block_ff;
   assign rsp_remaining    = rem_ff;

endmodule

// File: src/first_fit_block_allocator_unit.sv
// First-fit block allocator. A table holds the free size of each of NUM_BLOCKS
// memory blocks and reads as zero after reset. A load transaction (op 0) writes
// one block's free size and answers with the slot and size (a slot at or
// above NUM_BLOCKS is dropped and answered as not granted). A request
// transaction (op 1) walks blocks 0 up to csr block_count-1 (capped at
// NUM_BLOCKS), one table read per cycle, takes the first block whose free size
// is at least the wanted size, subtracts it and reports the block and what is
// left; with no fit, or a block count of zero, it answers not granted. A
// request reads at most min(block_count, NUM_BLOCKS) blocks through the
// single read port of the table; one transaction is worked on at a time.
// Results sit in an output register, and block_count may be written only
// while the unit is idle.
module first_fit_block_allocator_unit
   import ffba_pkg::*;
#(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_write_enable,
   input  logic [CFG_W-1:0]   csr_write_data,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic [FIELD_W-1:0] req_size_value,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_granted,
   output logic [SLOT_W-1:0]  rsp_block_number,
   output logic [FIELD_W-1:0] rsp_remaining
);

   ffba_cmd_type    cmd;
   ffba_status_type status;

   // sequencing of loads and scans
   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table, compare/subtract and result register
   ffba_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_WIDTH (SIZE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_slot         (req_slot),
      .req_size_value   (req_size_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_granted      (rsp_granted),
      .rsp_block_number (rsp_block_number),
      .rsp_remaining    (rsp_remaining)
   );

   // a denied transaction carries zero block and size
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_block_number == '0 && rsp_remaining == '0)
      else $error("denied response with nonzero payload");

   // at most one result capture per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.out_load, cmd.grant, cmd.out_deny}))
      else $error("conflicting result captures");

   // a grant is only issued for a fitting block
   assert property (@(posedge clock) disable iff (reset)
      cmd.grant |-> status.fits)
      else $error("grant without fit");

   // no new transaction is taken while a scan runs
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |=> !req_ready)
      else $error("request accepted during scan");

endmodule
